### rtl/sipf_pkg.sv
// Shared types, constants and the CRC step for the servo instruction packet framer.
// No dependencies; used by every module under rtl.
`default_nettype none

package sipf_pkg;

  // Command kinds as carried on the input tuser
  typedef enum logic [2:0] {
    KindPing     = 3'd0,
    KindRawWrite = 3'd1,
    KindSetPos   = 3'd2,
    KindSetVel   = 3'd3,
    KindProfile  = 3'd4
  } kind_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CfgServoId   = 3'd0,
    CfgMinPos    = 3'd1,
    CfgMaxPos    = 3'd2,
    CfgSpeedLim  = 3'd3,
    CfgPosAddr   = 3'd4,
    CfgVelAddr   = 3'd5
  } cfg_idx_e;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [7:0]  HdrA       = 8'hFF;
  localparam logic [7:0]  HdrB       = 8'hFD;
  localparam logic [7:0]  HdrRsvd    = 8'h00;
  localparam logic [7:0]  InstrPing  = 8'h01;
  localparam logic [7:0]  InstrWrite = 8'h03;
  localparam logic [7:0]  LenPing    = 8'h03;
  localparam logic [7:0]  LenWrite   = 8'h07;
  localparam logic [15:0] CrcPoly    = 16'h8005;
  localparam logic [15:0] ProfileMax = 16'd32767;

  // Index of the final (CRC high) byte for each packet form
  localparam logic [3:0]  LastIdxPing  = 4'd9;
  localparam logic [3:0]  LastIdxWrite = 4'd13;

  // Live configuration bundle
  typedef struct packed {
    logic [7:0]  servo_id;
    logic [11:0] min_position;
    logic [11:0] max_position;
    logic [15:0] speed_limit;
    logic [15:0] position_reg_address;
    logic [15:0] velocity_reg_address;
  } cfg_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic        is_ping;
    logic [15:0] addr;
    logic [15:0] value;
  } cmd_t;

  // One byte through the CRC-16 (poly 0x8005, MSB first)
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/sipf_front.sv
// Front end: takes command beats, drops unused kinds, clamps values, picks addresses.
// Depends on sipf_pkg; feeds sipf_queue.
`default_nettype none

module sipf_front (
  input  wire sipf_pkg::cfg_t  cfg_i,
  input  wire logic            s_valid_i,
  output logic                 s_ready_o,
  input  wire logic [2:0]      s_kind_i,
  input  wire logic [15:0]     s_addr_i,
  input  wire logic [15:0]     s_value_i,
  output logic                 push_valid_o,
  input  wire logic            push_ready_i,
  output sipf_pkg::cmd_t       push_cmd_o
);

  sipf_pkg::kind_e kind;
  logic [15:0]     max_ext;
  logic [15:0]     min_ext;
  logic [15:0]     pos_hi;
  logic            known;

  assign kind    = sipf_pkg::kind_e'(s_kind_i);
  assign max_ext = {4'b0000, cfg_i.max_position};
  assign min_ext = {4'b0000, cfg_i.min_position};
  assign pos_hi  = (s_value_i > max_ext) ? max_ext : s_value_i;

  // Classify the command and clamp its value
  always_comb begin
    known              = 1'b1;
    push_cmd_o.is_ping = 1'b0;
    push_cmd_o.addr    = s_addr_i;
    push_cmd_o.value   = s_value_i;
    unique case (kind)
      sipf_pkg::KindPing: begin
        push_cmd_o.is_ping = 1'b1;
      end
      sipf_pkg::KindRawWrite: begin
      end
      sipf_pkg::KindSetPos: begin
        push_cmd_o.addr  = cfg_i.position_reg_address;
        push_cmd_o.value = (pos_hi < min_ext) ? min_ext : pos_hi;
      end
      sipf_pkg::KindSetVel: begin
        push_cmd_o.addr  = cfg_i.velocity_reg_address;
        push_cmd_o.value = (s_value_i > cfg_i.speed_limit) ? cfg_i.speed_limit : s_value_i;
      end
      sipf_pkg::KindProfile: begin
        push_cmd_o.value = (s_value_i > sipf_pkg::ProfileMax) ? sipf_pkg::ProfileMax
                                                               : s_value_i;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // Unused kinds are accepted and dropped; hold the input only while the queue is full
  assign s_ready_o    = push_ready_i;
  assign push_valid_o = s_valid_i && known;

endmodule

`default_nettype wire

### rtl/sipf_queue.sv
// Short command queue between the front end and the packet serialiser.
// Depends on sipf_pkg for the command record.
`default_nettype none

module sipf_queue #(
  parameter int unsigned Depth = sipf_pkg::QueueDepthDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_valid_i,
  output logic                 push_ready_o,
  input  wire sipf_pkg::cmd_t  push_cmd_i,
  output logic                 pop_valid_o,
  input  wire logic            pop_ready_i,
  output sipf_pkg::cmd_t       pop_cmd_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  sipf_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntFull);
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign count_o      = cnt_q;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

### rtl/sipf_back.sv
// Back end: serialises one queued command into packet bytes with a running CRC-16.
// Depends on sipf_pkg; pops from sipf_queue and drives the output register.
`default_nettype none

module sipf_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire sipf_pkg::cfg_t  cfg_i,
  input  wire logic            pop_valid_i,
  output logic                 pop_ready_o,
  input  wire sipf_pkg::cmd_t  pop_cmd_i,
  output logic                 m_valid_o,
  input  wire logic            m_ready_i,
  output logic [7:0]           m_byte_o,
  output logic                 m_last_o
);

  sipf_pkg::cmd_t cmd_q;
  logic           busy_q;
  logic [3:0]     idx_q;
  logic [15:0]    crc_q;
  logic           out_valid_q;
  logic [7:0]     out_byte_q;
  logic           out_last_q;

  logic [3:0]     last_idx;
  logic           is_last, is_crc_lo, emit, load;
  logic [7:0]     cur_byte;

  assign last_idx  = cmd_q.is_ping ? sipf_pkg::LastIdxPing : sipf_pkg::LastIdxWrite;
  assign is_last   = (idx_q == last_idx);
  assign is_crc_lo = (idx_q == last_idx - 4'd1);
  assign emit      = busy_q && (!out_valid_q || m_ready_i);
  assign load      = pop_valid_i && (!busy_q || (emit && is_last));
  assign pop_ready_o = load;

  // Select the byte at the current position
  always_comb begin
    cur_byte = 8'h00;
    if (is_last) begin
      cur_byte = crc_q[15:8];
    end else if (is_crc_lo) begin
      cur_byte = crc_q[7:0];
    end else begin
      case (idx_q)
        4'd0, 4'd1: cur_byte = sipf_pkg::HdrA;
        4'd2:       cur_byte = sipf_pkg::HdrB;
        4'd3:       cur_byte = sipf_pkg::HdrRsvd;
        4'd4:       cur_byte = cfg_i.servo_id;
        4'd5:       cur_byte = cmd_q.is_ping ? sipf_pkg::LenPing : sipf_pkg::LenWrite;
        4'd6:       cur_byte = 8'h00;
        4'd7:       cur_byte = cmd_q.is_ping ? sipf_pkg::InstrPing : sipf_pkg::InstrWrite;
        4'd8:       cur_byte = cmd_q.addr[7:0];
        4'd9:       cur_byte = cmd_q.addr[15:8];
        4'd10:      cur_byte = cmd_q.value[7:0];
        4'd11:      cur_byte = cmd_q.value[15:8];
        default:    cur_byte = 8'h00;
      endcase
    end
  end

  // Sequence through the packet; a new command loads when idle or on the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      crc_q  <= '0;
    end else begin
      if (emit) begin
        idx_q <= idx_q + 4'd1;
        if (!is_last && !is_crc_lo) begin
          crc_q <= sipf_pkg::crc_feed(crc_q, cur_byte);
        end
        if (is_last) begin
          busy_q <= 1'b0;
        end
      end
      if (load) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
        crc_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= pop_cmd_i;
    end
  end

  // Output register: hold while stalled, drop valid once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= cur_byte;
      out_last_q <= is_last;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_byte_o  = out_byte_q;
  assign m_last_o  = out_last_q;

endmodule

`default_nettype wire

### rtl/servo_instruction_packet_framer.sv
// Top level of the servo instruction packet framer: config registers, front, queue, back.
// Depends on sipf_pkg, sipf_front, sipf_queue and sipf_back.
//
//   Channel  Dir  Beat carries
//   s_axis   in   tuser kind, tdata reg_address and write_value
//   m_axis   out  tdata tx_byte, tlast last_byte
//   cfg      in   cfg_addr_i register index, cfg_data_i value
//
// One packet byte leaves per cycle unless the output stalls; a ping is 10 bytes and
// a write 14, CRC-16 included. Commands queue up to QueueDepth deep while a packet
// is sent, and the next packet starts straight after a last byte. Unused kinds are
// accepted while the queue has room and produce nothing. Reset clears the queue, the
// serialiser and loads the register defaults; a stalled output holds the byte.
`default_nettype none

module servo_instruction_packet_framer #(
  parameter int unsigned QueueDepth = sipf_pkg::QueueDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [15:0] reg_address, [31:16] write_value
  input  wire logic [2:0]  s_axis_tuser,   // [2:0] kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] tx_byte
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [15:0] cfg_data_i
);

  sipf_pkg::cfg_t  cfg_q;
  sipf_pkg::cmd_t  push_cmd, pop_cmd;
  logic            push_valid, push_ready, pop_valid, pop_ready;
  logic [$clog2(QueueDepth+1)-1:0] q_count;
  logic            cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.servo_id             <= 8'd1;
      cfg_q.min_position         <= 12'd0;
      cfg_q.max_position         <= 12'd4095;
      cfg_q.speed_limit          <= 16'd1023;
      cfg_q.position_reg_address <= 16'd116;
      cfg_q.velocity_reg_address <= 16'd104;
    end else if (cfg_wr) begin
      unique case (sipf_pkg::cfg_idx_e'(cfg_addr_i))
        sipf_pkg::CfgServoId:  cfg_q.servo_id             <= cfg_data_i[7:0];
        sipf_pkg::CfgMinPos:   cfg_q.min_position         <= cfg_data_i[11:0];
        sipf_pkg::CfgMaxPos:   cfg_q.max_position         <= cfg_data_i[11:0];
        sipf_pkg::CfgSpeedLim: cfg_q.speed_limit          <= cfg_data_i;
        sipf_pkg::CfgPosAddr:  cfg_q.position_reg_address <= cfg_data_i;
        sipf_pkg::CfgVelAddr:  cfg_q.velocity_reg_address <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  sipf_front u_front (
    .cfg_i        (cfg_q),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_kind_i     (s_axis_tuser),
    .s_addr_i     (s_axis_tdata[15:0]),
    .s_value_i    (s_axis_tdata[31:16]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  sipf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd),
    .count_o      (q_count)
  );

  sipf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_cmd_i   (pop_cmd),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_byte_o    (m_axis_tdata),
    .m_last_o    (m_axis_tlast)
  );

  // Unused kinds never reach the queue
  a_drop_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tuser > sipf_pkg::KindProfile) |-> !push_valid)
    else $error("unused kind pushed into queue");

  // Occupancy never exceeds the queue depth
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= ($clog2(QueueDepth+1))'(QueueDepth))
    else $error("queue occupancy out of range");

  // A queued position lies within the limits when they are ordered
  a_pos_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid && s_axis_tuser == sipf_pkg::KindSetPos &&
     cfg_q.min_position <= cfg_q.max_position)
    |-> (push_cmd.value <= {4'b0000, cfg_q.max_position} &&
         push_cmd.value >= {4'b0000, cfg_q.min_position}))
    else $error("position value not clamped");

  // A queued velocity never exceeds the speed limit
  a_vel_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid && s_axis_tuser == sipf_pkg::KindSetVel)
    |-> (push_cmd.value <= cfg_q.speed_limit))
    else $error("velocity value not clamped");

endmodule

`default_nettype wire

### test/servo_instruction_packet_framer_tb.sv
// Self-checking testbench for servo_instruction_packet_framer.
// Depends on sipf_pkg and the RTL under rtl; drives commands and register writes and
// checks every output beat against a built-in packet predictor.
`timescale 1ns / 100ps

module servo_instruction_packet_framer_tb;

  // Kind codes the block accepts but turns into no packet
  localparam logic [2:0] KindUnusedLo = 3'd5;
  localparam logic [2:0] KindUnusedHi = 3'd7;
  // Register indexes with no register behind them
  localparam logic [2:0] CfgUnusedLo  = 3'd6;

  localparam int NumDirRows    = 21;
  localparam int NumPhases     = 8;
  localparam int ItemsPerPhase = 48;
  localparam int DrainCycles   = 24;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } out_beat_t;

  // One directed command; the hand-worked address and value are used when known
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] addr;
    logic [15:0] value;
    logic        known;
    logic [15:0] want_addr;
    logic [15:0] want_value;
  } cmd_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [15:0] reg_address, [31:16] write_value
  logic [2:0]  s_axis_tuser;   // [2:0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] tx_byte
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_addr_i;
  logic [15:0] cfg_data_i;

  sipf_pkg::cfg_t regs_copy;
  out_beat_t      pending_bytes [$];
  cmd_row_t       dir_rows [NumDirRows];
  int             mismatch_count;
  bit             no_idle;

  servo_instruction_packet_framer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Advance the CRC-16 over one byte, bit by bit, MSB first
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] data);
    logic fb;
    for (int b = 7; b >= 0; b--) begin
      fb  = crc[15] ^ data[b];
      crc = {crc[14:0], 1'b0};
      if (fb) crc = crc ^ sipf_pkg::CrcPoly;
    end
    return crc;
  endfunction

  // Queue the bytes of one instruction packet
  function automatic void frame_packet(bit is_ping, logic [15:0] addr, logic [15:0] value);
    logic [7:0]  bytes [14];
    logic [15:0] crc;
    int          n;
    bytes[0] = sipf_pkg::HdrA;
    bytes[1] = sipf_pkg::HdrA;
    bytes[2] = sipf_pkg::HdrB;
    bytes[3] = sipf_pkg::HdrRsvd;
    bytes[4] = regs_copy.servo_id;
    bytes[6] = 8'h00;
    if (is_ping) begin
      bytes[5] = sipf_pkg::LenPing;
      bytes[7] = sipf_pkg::InstrPing;
      n = 8;
    end else begin
      bytes[5]  = sipf_pkg::LenWrite;
      bytes[7]  = sipf_pkg::InstrWrite;
      bytes[8]  = addr[7:0];
      bytes[9]  = addr[15:8];
      bytes[10] = value[7:0];
      bytes[11] = value[15:8];
      n = 12;
    end
    crc = 16'h0000;
    for (int i = 0; i < n; i++) crc = crc16_byte(crc, bytes[i]);
    bytes[n]     = crc[7:0];
    bytes[n + 1] = crc[15:8];
    for (int i = 0; i < n + 2; i++) pending_bytes.push_back('{bytes[i], i == n + 1});
  endfunction

  // Apply the clamps and address choice of each kind, then frame the packet
  function automatic void predict_command(logic [2:0] kind, logic [15:0] addr,
                                          logic [15:0] value);
    logic [15:0] v;
    logic [15:0] a;
    v = value;
    a = addr;
    case (kind)
      sipf_pkg::KindPing, sipf_pkg::KindRawWrite: ;
      sipf_pkg::KindSetPos: begin
        if (v > {4'h0, regs_copy.max_position}) v = {4'h0, regs_copy.max_position};
        if (v < {4'h0, regs_copy.min_position}) v = {4'h0, regs_copy.min_position};
        a = regs_copy.position_reg_address;
      end
      sipf_pkg::KindSetVel: begin
        if (v > regs_copy.speed_limit) v = regs_copy.speed_limit;
        a = regs_copy.velocity_reg_address;
      end
      sipf_pkg::KindProfile: begin
        if (v > sipf_pkg::ProfileMax) v = sipf_pkg::ProfileMax;
      end
      default: return;   // unused kind: no packet
    endcase
    frame_packet(kind == sipf_pkg::KindPing, a, v);
  endfunction

  // Offer one command beat after a random gap and hold it until taken
  task automatic send_command(logic [2:0] kind, logic [15:0] addr, logic [15:0] value);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {value, addr};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Write one register and mirror it in the local copy
  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      sipf_pkg::CfgServoId:  regs_copy.servo_id             = data[7:0];
      sipf_pkg::CfgMinPos:   regs_copy.min_position         = data[11:0];
      sipf_pkg::CfgMaxPos:   regs_copy.max_position         = data[11:0];
      sipf_pkg::CfgSpeedLim: regs_copy.speed_limit          = data;
      sipf_pkg::CfgPosAddr:  regs_copy.position_reg_address = data;
      sipf_pkg::CfgVelAddr:  regs_copy.velocity_reg_address = data;
      default: ;
    endcase
  endtask

  task automatic program_regs(sipf_pkg::cfg_t c);
    write_reg(sipf_pkg::CfgServoId,  {8'h00, c.servo_id});
    write_reg(sipf_pkg::CfgMinPos,   {4'h0, c.min_position});
    write_reg(sipf_pkg::CfgMaxPos,   {4'h0, c.max_position});
    write_reg(sipf_pkg::CfgSpeedLim, c.speed_limit);
    write_reg(sipf_pkg::CfgPosAddr,  c.position_reg_address);
    write_reg(sipf_pkg::CfgVelAddr,  c.velocity_reg_address);
    // an index with no register behind it must change nothing
    if ($urandom_range(0, 1) != 0)
      write_reg(CfgUnusedLo + 3'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
    cfg_valid_i <= 1'b0;
  endtask

  // Drop the command valid, let every packet drain, then allow for trailing unused kinds
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Register settings per phase: both extremes, crossed position limits, then random
  function automatic sipf_pkg::cfg_t phase_regs(int ph);
    sipf_pkg::cfg_t c;
    logic [11:0]    p;
    logic [11:0]    q;
    case (ph)
      0: c = '{8'd253, 12'hFFF, 12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
      1: c = '{8'd0, 12'h000, 12'h000, 16'h0000, 16'h0000, 16'h0000};
      2: c = '{8'($urandom_range(0, 253)), 12'd3000, 12'd1000, 16'd500,
               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))};
      default: begin
        p = 12'($urandom_range(0, 4095));
        q = 12'($urandom_range(0, 4095));
        c.servo_id             = 8'($urandom_range(0, 253));
        c.min_position         = (p < q) ? p : q;
        c.max_position         = (p < q) ? q : p;
        c.speed_limit          = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 65535))
                                                             : 16'($urandom_range(0, 2047));
        c.position_reg_address = 16'($urandom_range(0, 65535));
        c.velocity_reg_address = 16'($urandom_range(0, 65535));
      end
    endcase
    return c;
  endfunction

  // Value around the clamp edge of the kind, or an extreme, or anything
  function automatic logic [15:0] pick_value(logic [2:0] kind);
    logic [15:0] edge_val;
    case (kind)
      sipf_pkg::KindSetPos:
        edge_val = ($urandom_range(0, 1) != 0) ? {4'h0, regs_copy.max_position}
                                               : {4'h0, regs_copy.min_position};
      sipf_pkg::KindSetVel:  edge_val = regs_copy.speed_limit;
      sipf_pkg::KindProfile: edge_val = sipf_pkg::ProfileMax;
      default:               edge_val = 16'($urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 5))
      0, 1:    return edge_val + 16'($urandom_range(0, 2)) - 16'd1;
      2:       return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Sink side: stall a random number of cycles ahead of each byte
  initial begin
    int stall;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Compare each output beat with the oldest expected byte
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected beat: tx_byte %h last_byte %b", m_axis_tdata, m_axis_tlast);
        mismatch_count++;
      end else begin
        want = pending_bytes.pop_front();
        if (m_axis_tdata !== want.tx_byte) begin
          $error("tx_byte: expected %h, got %h", want.tx_byte, m_axis_tdata);
          mismatch_count++;
        end
        if (m_axis_tlast !== want.last_byte) begin
          $error("last_byte: expected %b, got %b", want.last_byte, m_axis_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic [2:0]  kind;
    logic [15:0] addr;
    logic [15:0] value;
    cmd_row_t    row;
    mismatch_count = 0;
    no_idle        = 1'b0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    m_axis_tready  = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_addr_i     = '0;
    cfg_data_i     = '0;
    regs_copy      = '{8'd1, 12'd0, 12'd4095, 16'd1023, 16'd116, 16'd104};

    // Directed commands at reset settings; hand-worked address and value where obvious
    dir_rows = '{
      '{sipf_pkg::KindPing,     16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000},
      '{sipf_pkg::KindPing,     16'hFFFF, 16'hFFFF, 1'b1, 16'h0000, 16'h0000},
      '{sipf_pkg::KindRawWrite, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000},
      '{sipf_pkg::KindRawWrite, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF},
      '{sipf_pkg::KindRawWrite, 16'h1234, 16'hA5A5, 1'b1, 16'h1234, 16'hA5A5},
      '{sipf_pkg::KindRawWrite, 16'hAAAA, 16'h5555, 1'b1, 16'hAAAA, 16'h5555},
      '{sipf_pkg::KindSetPos,   16'hFFFF, 16'd0,    1'b1, 16'd116,  16'd0},
      '{sipf_pkg::KindSetPos,   16'h0000, 16'd4095, 1'b1, 16'd116,  16'd4095},
      '{sipf_pkg::KindSetPos,   16'h0000, 16'd4096, 1'b1, 16'd116,  16'd4095},
      '{sipf_pkg::KindSetPos,   16'h0000, 16'hFFFF, 1'b1, 16'd116,  16'd4095},
      '{sipf_pkg::KindSetVel,   16'hFFFF, 16'd1023, 1'b1, 16'd104,  16'd1023},
      '{sipf_pkg::KindSetVel,   16'h0000, 16'd1024, 1'b1, 16'd104,  16'd1023},
      '{sipf_pkg::KindSetVel,   16'h0000, 16'hFFFF, 1'b1, 16'd104,  16'd1023},
      '{sipf_pkg::KindSetVel,   16'h0000, 16'd0,    1'b1, 16'd104,  16'd0},
      '{sipf_pkg::KindProfile,  16'h0070, 16'd32767, 1'b1, 16'h0070, 16'd32767},
      '{sipf_pkg::KindProfile,  16'h0070, 16'd32768, 1'b1, 16'h0070, 16'd32767},
      '{sipf_pkg::KindProfile,  16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 16'd32767},
      '{sipf_pkg::KindProfile,  16'h0000, 16'd0,    1'b1, 16'h0000, 16'd0},
      '{KindUnusedLo,        16'hFFFF, 16'hFFFF, 1'b0, 16'h0000, 16'h0000},
      '{KindUnusedLo + 3'd1, 16'h1234, 16'h5678, 1'b0, 16'h0000, 16'h0000},
      '{KindUnusedHi,        16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000}
    };

    // Hold reset, then release it
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_command(row.kind, row.addr, row.value);
      if (row.known) begin
        frame_packet(row.kind == sipf_pkg::KindPing, row.want_addr, row.want_value);
      end else begin
        predict_command(row.kind, row.addr, row.value);
      end
    end

    // Random commands, one batch per register setting
    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_idle();
      program_regs(phase_regs(ph));
      no_idle = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if ($urandom_range(0, 19) < 2)
          kind = KindUnusedLo + 3'($urandom_range(0, 2));
        else
          kind = 3'($urandom_range(0, 4));
        addr  = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
        value = pick_value(kind);
        send_command(kind, addr, value);
        predict_command(kind, addr, value);
      end
    end
    wait_idle();

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: ends a hung run
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
